@@ rtl/brl_pkg.sv @@
// shared types and constants for the line rasterizer
// no dependencies
`default_nettype none

package brl_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int QDEPTH     = 2;
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic [QCNT_BITS-1:0]       qcnt_t;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // classified command word passed from front to back
    typedef struct packed {
        logic   is_start;
        coord_t x;
        coord_t y;
        coord_t major;
        coord_t minor;
        logic   x_neg;
        logic   y_neg;
        logic   x_major;
    } cmd_t;

    // one emitted pixel
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pix_t;

endpackage

`default_nettype wire

@@ rtl/brl_front.sv @@
// front end: takes input words, works out deltas, signs and major axis
// depends on brl_pkg
`default_nettype none

module brl_front
    import brl_pkg::*;
(
    input  wire logic   push,
    output logic        full,
    input  wire logic   action,
    input  wire coord_t x_start,
    input  wire coord_t y_start,
    input  wire coord_t x_end,
    input  wire coord_t y_end,
    input  wire logic   q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    coord_t adx;
    coord_t ady;
    logic   x_neg;
    logic   y_neg;
    logic   x_major;

    always_comb
    begin
        x_neg   = x_end < x_start;
        y_neg   = y_end < y_start;
        adx     = x_neg ? (x_start - x_end) : (x_end - x_start);
        ady     = y_neg ? (y_start - y_end) : (y_end - y_start);
        // equal deltas make y the major axis
        x_major = adx > ady;

        q_cmd.is_start = (action == ACT_START);
        q_cmd.x        = x_start;
        q_cmd.y        = y_start;
        q_cmd.major    = x_major ? adx : ady;
        q_cmd.minor    = x_major ? ady : adx;
        q_cmd.x_neg    = x_neg;
        q_cmd.y_neg    = y_neg;
        q_cmd.x_major  = x_major;
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

endmodule

`default_nettype wire

@@ rtl/brl_cmd_queue.sv @@
// two-entry command queue between front and back
// depends on brl_pkg
`default_nettype none

module brl_cmd_queue
    import brl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      q_full,
    input  wire logic rd_en,
    output logic      q_empty,
    output cmd_t      rd_data
);

    cmd_t  mem_reg [QDEPTH];
    logic  wr_ptr_reg;
    logic  wr_ptr_next;
    logic  rd_ptr_reg;
    logic  rd_ptr_next;
    qcnt_t cnt_reg;
    qcnt_t cnt_next;
    logic  do_wr;
    logic  do_rd;

    assign q_full  = (cnt_reg == qcnt_t'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        do_wr       = wr_en && !q_full;
        do_rd       = rd_en && !q_empty;
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + qcnt_t'(do_wr) - qcnt_t'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/brl_back.sv @@
// back end: stepping state, error term and two-entry result queue
// depends on brl_pkg
`default_nettype none

module brl_back
    import brl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      empty,
    input  wire logic pop,
    output coord_t    pixel_x,
    output coord_t    pixel_y,
    output logic      last_pixel
);

    // stepping state
    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t steps_reg, steps_next;
    err_t   err_reg, err_next;
    err_t   inc_lo_reg, inc_lo_next;
    err_t   inc_hi_reg, inc_hi_next;
    logic   x_neg_reg, x_neg_next;
    logic   y_neg_reg, y_neg_next;
    logic   x_major_reg, x_major_next;
    logic   busy_reg, busy_next;

    // result queue
    pix_t   out_mem_reg [QDEPTH];
    logic   owr_ptr_reg, owr_ptr_next;
    logic   ord_ptr_reg, ord_ptr_next;
    qcnt_t  ocnt_reg, ocnt_next;

    logic   out_room;
    logic   emit;
    logic   out_rd;
    pix_t   emit_pix;
    err_t   two_minor;
    err_t   two_major;
    err_t   major_ext;
    coord_t step_x;
    coord_t step_y;
    coord_t steps_dec;
    logic   minor_step;

    assign out_room   = (ocnt_reg != qcnt_t'(QDEPTH));
    assign q_pop      = !q_empty && out_room;
    assign empty      = (ocnt_reg == '0);
    assign out_rd     = pop && !empty;
    assign pixel_x    = out_mem_reg[ord_ptr_reg].x;
    assign pixel_y    = out_mem_reg[ord_ptr_reg].y;
    assign last_pixel = out_mem_reg[ord_ptr_reg].last;

    always_comb
    begin
        two_minor = {{(ERR_BITS-COORD_BITS-1){1'b0}}, q_cmd.minor, 1'b0};
        two_major = {{(ERR_BITS-COORD_BITS-1){1'b0}}, q_cmd.major, 1'b0};
        major_ext = {{(ERR_BITS-COORD_BITS){1'b0}}, q_cmd.major};

        step_x     = x_neg_reg ? (cur_x_reg - coord_t'(1)) : (cur_x_reg + coord_t'(1));
        step_y     = y_neg_reg ? (cur_y_reg - coord_t'(1)) : (cur_y_reg + coord_t'(1));
        steps_dec  = steps_reg - coord_t'(1);
        minor_step = !err_reg[ERR_BITS-1];

        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        steps_next   = steps_reg;
        err_next     = err_reg;
        inc_lo_next  = inc_lo_reg;
        inc_hi_next  = inc_hi_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        x_major_next = x_major_reg;
        busy_next    = busy_reg;
        emit         = 1'b0;

        if (q_pop)
        begin
            if (q_cmd.is_start)
            begin
                // start: load state and show the first endpoint
                cur_x_next   = q_cmd.x;
                cur_y_next   = q_cmd.y;
                steps_next   = q_cmd.major;
                err_next     = two_minor - major_ext;
                inc_lo_next  = two_minor;
                inc_hi_next  = two_minor - two_major;
                x_neg_next   = q_cmd.x_neg;
                y_neg_next   = q_cmd.y_neg;
                x_major_next = q_cmd.x_major;
                busy_next    = (q_cmd.major != '0);
                emit         = 1'b1;
            end
            else if (busy_reg)
            begin
                // advance one pixel along the major axis
                if (x_major_reg || minor_step)
                begin
                    cur_x_next = step_x;
                end
                if (!x_major_reg || minor_step)
                begin
                    cur_y_next = step_y;
                end
                err_next   = err_reg + (minor_step ? inc_hi_reg : inc_lo_reg);
                steps_next = steps_dec;
                busy_next  = (steps_dec != '0);
                emit       = 1'b1;
            end
        end

        emit_pix.x    = cur_x_next;
        emit_pix.y    = cur_y_next;
        emit_pix.last = (steps_next == '0);

        owr_ptr_next = emit ? ~owr_ptr_reg : owr_ptr_reg;
        ord_ptr_next = out_rd ? ~ord_ptr_reg : ord_ptr_reg;
        ocnt_next    = ocnt_reg + qcnt_t'(emit) - qcnt_t'(out_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            steps_reg   <= '0;
            err_reg     <= '0;
            inc_lo_reg  <= '0;
            inc_hi_reg  <= '0;
            x_neg_reg   <= 1'b0;
            y_neg_reg   <= 1'b0;
            x_major_reg <= 1'b0;
            busy_reg    <= 1'b0;
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocnt_reg    <= '0;
        end
        else
        begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            steps_reg   <= steps_next;
            err_reg     <= err_next;
            inc_lo_reg  <= inc_lo_next;
            inc_hi_reg  <= inc_hi_next;
            x_neg_reg   <= x_neg_next;
            y_neg_reg   <= y_neg_next;
            x_major_reg <= x_major_next;
            busy_reg    <= busy_next;
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocnt_reg    <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_mem_reg[owr_ptr_reg] <= emit_pix;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bresenham_line_rasterizer_core.sv @@
// top level of the bresenham line rasterizer
// depends on brl_pkg, brl_front, brl_cmd_queue, brl_back
`default_nettype none

//  channel   direction  handshake         fields
//  ------------------------------------------------------------------------------
//  input     in         push / full       action, x_start, y_start, x_end, y_end
//  result    out        empty / pop       pixel_x, pixel_y, last_pixel
//
//  one word per cycle sustained while the result side keeps popping; a word is
//  registered in the command queue, its pixel then in the result queue, which
//  drives the pixel ports; the back end's bresenham add and compare sets the rate
//  reset clears both queues and the stepping state; the block is then idle
//  a stall on the result side fills the result queue, then the command queue,
//  then raises full; an advance word while idle is consumed with no result

module bresenham_line_rasterizer_core
    import brl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    // input queue side
    input  wire logic   push,
    output logic        full,
    input  wire logic   action,
    input  wire coord_t x_start,
    input  wire coord_t y_start,
    input  wire coord_t x_end,
    input  wire coord_t y_end,
    // result queue side
    output logic        empty,
    input  wire logic   pop,
    output coord_t      pixel_x,
    output coord_t      pixel_y,
    output logic        last_pixel
);

    // front to queue
    logic q_full;
    logic q_push;
    cmd_t q_wr_cmd;

    // queue to back
    logic q_empty;
    logic q_pop;
    cmd_t q_rd_cmd;

    // classify the word and work out deltas and axis
    brl_front u_front
    (
        .push    (push),
        .full    (full),
        .action  (action),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_wr_cmd)
    );

    // short queue so front and back stall independently
    brl_cmd_queue u_cmd_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_rd_cmd)
    );

    // stepping engine and result queue
    brl_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (q_rd_cmd),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

`default_nettype wire

@@ tb/brl_checker.sv @@
// scoreboard for the line rasterizer: watches both queue sides, predicts pixels
// and compares them; depends on brl_pkg
`timescale 1ns / 1ps

module brl_checker
    import brl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  logic   full,
    input  logic   action,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,
    input  logic   empty,
    input  logic   pop,
    input  coord_t pixel_x,
    input  coord_t pixel_y,
    input  logic   last_pixel,
    output int     errors,
    output int     pending,
    output int     words_in,
    output int     lines_started,
    output int     pixels_checked
);

    pix_t   awaited_pixels[$];

    // shadow of the stepping state
    coord_t pos_x, pos_y, pixels_left, run_len, rise;
    err_t   decision;
    logic   x_back, y_back, walk_x, line_open;

    initial
    begin
        errors         = 0;
        pending        = 0;
        words_in       = 0;
        lines_started  = 0;
        pixels_checked = 0;
    end

    function automatic coord_t nudge(coord_t c, logic back);
        return back ? c - 1'b1 : c + 1'b1;
    endfunction

    task automatic clear_line();
        pos_x       = '0;
        pos_y       = '0;
        pixels_left = '0;
        run_len     = '0;
        rise        = '0;
        decision    = '0;
        x_back      = 1'b0;
        y_back      = 1'b0;
        walk_x      = 1'b0;
        line_open   = 1'b0;
    endtask

    task automatic step_line(logic act, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
        coord_t adx;
        coord_t ady;
        adx = (xe >= xs) ? xe - xs : xs - xe;
        ady = (ye >= ys) ? ye - ys : ys - ye;
        if (act == ACT_START)
        begin
            x_back      = xe < xs;
            y_back      = ye < ys;
            walk_x      = adx > ady;
            run_len     = walk_x ? adx : ady;
            rise        = walk_x ? ady : adx;
            decision    = err_t'(2 * int'(rise) - int'(run_len));
            pos_x       = xs;
            pos_y       = ys;
            pixels_left = run_len;
            line_open   = run_len != '0;
            lines_started++;
        end
        else if (line_open)
        begin
            if (walk_x)
                pos_x = nudge(pos_x, x_back);
            else
                pos_y = nudge(pos_y, y_back);
            if (decision < 0)
                decision = err_t'(int'(decision) + 2 * int'(rise));
            else
            begin
                if (walk_x)
                    pos_y = nudge(pos_y, y_back);
                else
                    pos_x = nudge(pos_x, x_back);
                decision = err_t'(int'(decision) + 2 * int'(rise) - 2 * int'(run_len));
            end
            pixels_left = pixels_left - 1'b1;
            if (pixels_left == '0)
                line_open = 1'b0;
        end
        else
            return;   // advance while idle gives no pixel
        awaited_pixels.push_back('{x: pos_x, y: pos_y, last: pixels_left == '0});
    endtask

    initial clear_line();

    always @(posedge clk)
    begin : watch
        pix_t want;
        if (!rst_n)
        begin
            clear_line();
            awaited_pixels.delete();
        end
        else
        begin
            if (push && !full)
            begin
                words_in++;
                step_line(action, x_start, y_start, x_end, y_end);
            end
            if (pop && !empty)
            begin
                if (awaited_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: pixel (%0d,%0d) last=%0b with none awaited",
                                 $realtime, pixel_x, pixel_y, last_pixel);
                end
                else
                begin
                    want = awaited_pixels.pop_front();
                    pixels_checked++;
                    if (pixel_x !== want.x || pixel_y !== want.y || last_pixel !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
                                     $realtime, want.x, want.y, want.last,
                                     pixel_x, pixel_y, last_pixel);
                    end
                end
            end
        end
        pending = awaited_pixels.size();
    end

endmodule

@@ tb/tb_top.sv @@
// top of the line rasterizer testbench: clock, reset, word stimulus and verdict
// depends on brl_pkg, brl_checker and the rasterizer rtl
`timescale 1ns / 1ps

module tb_top;
    import brl_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;   // far beyond the slowest correct run
    localparam int RANDOM_WORDS = 700;
    localparam int PHASES       = 3;

    logic   clk;
    logic   rst_n      = 1'b0;
    logic   push       = 1'b0;
    logic   action     = ACT_START;
    coord_t x_start    = '0;
    coord_t y_start    = '0;
    coord_t x_end      = '0;
    coord_t y_end      = '0;
    logic   pop        = 1'b0;
    logic   full;
    logic   empty;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    int errors, pending, words_in, lines_started, pixels_checked;

    // idling odds in percent, changed per phase
    int tx_idle_pct = 9;
    int rx_idle_pct = 49;

    int cycles      = 0;
    int line_left   = 0;   // pixels the current line still owes
    int useful      = 0;   // words that start a line or move one along

    bresenham_line_rasterizer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .empty      (empty),
        .pop        (pop),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    brl_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .x_start        (x_start),
        .y_start        (y_start),
        .x_end          (x_end),
        .y_end          (y_end),
        .empty          (empty),
        .pop            (pop),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .last_pixel     (last_pixel),
        .errors         (errors),
        .pending        (pending),
        .words_in       (words_in),
        .lines_started  (lines_started),
        .pixels_checked (pixels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d pixels outstanding", cycles, pending);
            $display("FAIL bresenham_line_rasterizer_core");
            $finish;
        end
    end

    // receiver side: pop drawn afresh at every falling edge
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);

    function automatic int line_len(int xs, int ys, int xe, int ye);
        int adx;
        int ady;
        adx = (xe > xs) ? xe - xs : xs - xe;
        ady = (ye > ys) ? ye - ys : ys - ye;
        return (adx > ady) ? adx : ady;
    endfunction

    // endpoint within span of c, mirrored back when it falls off the grid
    function automatic int near(int c, int span);
        int d;
        int e;
        d = int'($urandom_range(0, 2 * span)) - span;
        e = c + d;
        if (e < 0 || e > 4095)
            e = c - d;
        return e;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance;
    // push is only lowered while idling so it never gets two updates in one step
    task automatic send_word(logic act, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        action  <= act;
        x_start <= xs;
        y_start <= ys;
        x_end   <= xe;
        y_end   <= ye;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // endpoint fields carry noise on an advance, the block must ignore them
    task automatic advance();
        send_word(ACT_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
        if (line_left > 0)
        begin
            line_left--;
            useful++;
        end
    endtask

    // start a line and move it on by a number of pixels; fewer than its length
    // abandons it, more gives idle advances
    task automatic draw(int xs, int ys, int xe, int ye, int steps);
        send_word(ACT_START, coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye));
        line_left = line_len(xs, ys, xe, ye);
        useful++;
        repeat (steps)
            advance();
    endtask

    // hold the sender off until every predicted pixel has been taken
    task automatic drain();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int xs, ys, xe, ye, span, steps, pick, d;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed lines
        advance();                              // advance straight after reset
        draw(0, 0, 0, 0, 0);                    // single point at the origin
        draw(4095, 4095, 4095, 4095, 1);        // single point at the far corner, then idle advance
        draw(0, 0, 4095, 4095, 2);              // equal deltas, y major; abandoned
        draw(4095, 0, 0, 4095, 1);              // restart while busy, x falling
        draw(0, 4095, 4095, 4093, 1);           // long x major, y falling; abandoned
        draw(10, 5, 7, 6, 4);                   // short x major backwards plus an idle advance
        draw(5, 10, 6, 7, 3);                   // short y major backwards
        draw(100, 100, 98, 100, 2);             // horizontal
        draw(100, 100, 100, 102, 2);            // vertical
        drain();

        useful = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 9;  rx_idle_pct = 49; end
                1:       begin tx_idle_pct = 49; rx_idle_pct = 9;  end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            while (useful < RANDOM_WORDS * (phase + 1) / PHASES)
            begin
                pick = $urandom_range(0, 99);
                xs   = $urandom_range(0, 4095);
                ys   = $urandom_range(0, 4095);
                if (pick < 70)
                begin
                    // short line run to its end, now and then cut short or overrun
                    span  = ($urandom_range(0, 9) == 0) ? 300 : 12;
                    xe    = near(xs, span);
                    ye    = near(ys, span);
                    steps = line_len(xs, ys, xe, ye);
                    case ($urandom_range(0, 9))
                        0:       steps = $urandom_range(0, steps);
                        1:       steps += $urandom_range(1, 2);
                        default: ;
                    endcase
                    draw(xs, ys, xe, ye, steps);
                end
                else if (pick < 78)
                begin
                    // diagonal or axis-aligned line, both signs
                    d  = $urandom_range(0, 20);
                    xe = ($urandom_range(0, 1) != 0) ? near(xs, 0) + d : xs - d;
                    ye = ($urandom_range(0, 1) != 0) ? ys + d : ys - d;
                    if ($urandom_range(0, 2) == 0)
                        ye = ys;
                    if (xe < 0 || xe > 4095) xe = xs;
                    if (ye < 0 || ye > 4095) ye = ys;
                    draw(xs, ys, xe, ye, line_len(xs, ys, xe, ye));
                end
                else if (pick < 88)
                begin
                    repeat ($urandom_range(1, 3))
                        advance();
                end
                else
                begin
                    // endpoints anywhere on the grid, abandoned after a few pixels
                    draw(xs, ys, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 6));
                end
            end
            drain();
        end

        // wait out the command queue and result queue registers of the block, with margin
        repeat (8) @(negedge clk);

        $display("covered %0d words in, %0d lines in all octants, %0d pixels compared",
                 words_in, lines_started, pixels_checked);
        if (pending != 0)
            $display("%0d predicted pixels never came out", pending);
        if (errors == 0 && pending == 0)
            $display("PASS bresenham_line_rasterizer_core");
        else
            $display("FAIL bresenham_line_rasterizer_core");
        $finish;
    end

endmodule
